### hw/rtl/bfbp_pkg.sv
// bfbp_pkg: shared widths, codes, controller states and the
// command/status structs that join the controller and the datapath
// no dependencies
package bfbp_pkg;

  // payload widths
  localparam int SIZE_W   = 31;
  localparam int HANDLE_W = 32;
  localparam int ENTRY_W  = HANDLE_W + SIZE_W;
  localparam int LIMIT_W  = 5;

  // defaults
  localparam int                POOL_DEPTH_DEFAULT = 16;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET       = 5'd16;

  // request kinds
  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_DRAIN,
    ST_CHECK,
    ST_MOVE,
    ST_OUT
  } bfbp_state_t;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic load_item;
    logic rel_write;
    logic rel_drop;
    logic scan_rd;
    logic last_rd;
    logic move_write;
    logic load_out;
  } bfbp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_release;
    logic count_zero;
    logic can_append;
    logic scan_last;
    logic hit;
    logic out_free;
  } bfbp_status_t;

endpackage

### hw/rtl/bfbp_ctrl.sv
// bfbp_ctrl: sequencing state machine for release, best-fit scan and
// swap-remove; depends on bfbp_pkg
module bfbp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  bfbp_pkg::bfbp_status_t sts,
  output bfbp_pkg::bfbp_cmd_t    cmd
);

  bfbp_pkg::bfbp_state_t state;
  bfbp_pkg::bfbp_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfbp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bfbp_pkg::ST_IDLE: begin
        if (in_valid) state_next = bfbp_pkg::ST_DISPATCH;
      end
      bfbp_pkg::ST_DISPATCH: begin
        if (sts.is_release || sts.count_zero) state_next = bfbp_pkg::ST_OUT;
        else state_next = bfbp_pkg::ST_SCAN;
      end
      bfbp_pkg::ST_SCAN: begin
        if (sts.scan_last) state_next = bfbp_pkg::ST_DRAIN;
      end
      bfbp_pkg::ST_DRAIN: begin
        state_next = bfbp_pkg::ST_CHECK;
      end
      bfbp_pkg::ST_CHECK: begin
        if (sts.hit) state_next = bfbp_pkg::ST_MOVE;
        else state_next = bfbp_pkg::ST_OUT;
      end
      bfbp_pkg::ST_MOVE: begin
        state_next = bfbp_pkg::ST_OUT;
      end
      bfbp_pkg::ST_OUT: begin
        if (sts.out_free) state_next = bfbp_pkg::ST_IDLE;
      end
      default: begin
        state_next = bfbp_pkg::ST_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    case (state)
      bfbp_pkg::ST_IDLE: begin
        cmd.in_ready  = 1'b1;
        cmd.load_item = in_valid;
      end
      bfbp_pkg::ST_DISPATCH: begin
        cmd.rel_write = sts.is_release && sts.can_append;
        cmd.rel_drop  = sts.is_release && !sts.can_append;
      end
      bfbp_pkg::ST_SCAN: begin
        cmd.scan_rd = 1'b1;
      end
      bfbp_pkg::ST_CHECK: begin
        cmd.last_rd = sts.hit;
      end
      bfbp_pkg::ST_MOVE: begin
        cmd.move_write = 1'b1;
      end
      bfbp_pkg::ST_OUT: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### hw/rtl/bfbp_dp.sv
// bfbp_dp: pool memory, entry count, scan counter, best-fit compare
// and the result register; depends on bfbp_pkg
module bfbp_dp #(
  parameter int POOL_DEPTH = bfbp_pkg::POOL_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bfbp_pkg::LIMIT_W-1:0]     cfg_wdata,
  input  logic                             kind,
  input  logic [bfbp_pkg::SIZE_W-1:0]      block_size,
  input  logic [bfbp_pkg::HANDLE_W-1:0]    release_handle,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic                             found,
  output logic [bfbp_pkg::HANDLE_W-1:0]    granted_handle,
  output logic [bfbp_pkg::SIZE_W-1:0]      granted_size,
  output logic                             dropped,
  input  bfbp_pkg::bfbp_cmd_t               cmd,
  output bfbp_pkg::bfbp_status_t            sts
);

  localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W = $clog2(POOL_DEPTH + 1);
  localparam int CMP_W = (CNT_W > bfbp_pkg::LIMIT_W) ? CNT_W : bfbp_pkg::LIMIT_W;
  localparam int SW    = bfbp_pkg::SIZE_W;
  localparam int HW    = bfbp_pkg::HANDLE_W;

  logic [bfbp_pkg::ENTRY_W-1:0] pool_mem [POOL_DEPTH];
  logic [bfbp_pkg::ENTRY_W-1:0] rd_data;
  logic [bfbp_pkg::ENTRY_W-1:0] wr_data;
  logic [IDX_W-1:0]             rd_addr;
  logic [IDX_W-1:0]             wr_addr;
  logic                         wr_en;

  logic [bfbp_pkg::LIMIT_W-1:0] pool_limit;
  logic [CNT_W-1:0]             entry_count;
  logic [CNT_W-1:0]             count_m1;
  logic [IDX_W-1:0]             scan_idx;
  logic [IDX_W-1:0]             cmp_idx;
  logic                         cmp_valid;

  logic                         req_kind;
  logic [SW-1:0]                req_size;
  logic [HW-1:0]                req_handle;

  logic                         hit;
  logic                         drop_flag;
  logic [IDX_W-1:0]             best_idx;
  logic [SW-1:0]                best_size;
  logic [HW-1:0]                best_handle;

  logic [SW-1:0]                rd_size;
  logic [HW-1:0]                rd_handle;
  logic                         better;

  assign count_m1  = entry_count - CNT_W'(1);
  assign rd_size   = rd_data[SW-1:0];
  assign rd_handle = rd_data[bfbp_pkg::ENTRY_W-1:SW];

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_limit <= bfbp_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      pool_limit <= cfg_wdata;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      req_kind   <= kind;
      req_size   <= block_size;
      req_handle <= release_handle;
    end
  end

  // memory address and write data selection
  assign rd_addr = cmd.last_rd ? count_m1[IDX_W-1:0] : scan_idx;
  assign wr_en   = cmd.rel_write || cmd.move_write;
  assign wr_addr = cmd.move_write ? best_idx : entry_count[IDX_W-1:0];
  assign wr_data = cmd.move_write ? rd_data : {req_handle, req_size};

  // pool memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pool_mem[wr_addr] <= wr_data;
    end
    if (cmd.scan_rd || cmd.last_rd) begin
      rd_data <= pool_mem[rd_addr];
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cmd.rel_write) begin
      entry_count <= entry_count + CNT_W'(1);
    end else if (cmd.move_write) begin
      entry_count <= count_m1;
    end
  end

  // scan counter and compare pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= cmd.scan_rd;
    end
    if (cmd.load_item) begin
      scan_idx <= '0;
    end else if (cmd.scan_rd) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
    cmp_idx <= scan_idx;
  end

  // best-fit selection, strict less keeps the lowest slot on a tie
  assign better = cmp_valid && (rd_size >= req_size) && (!hit || rd_size < best_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit       <= 1'b0;
      drop_flag <= 1'b0;
    end else if (cmd.load_item) begin
      hit       <= 1'b0;
      drop_flag <= 1'b0;
    end else begin
      if (better) hit <= 1'b1;
      if (cmd.rel_drop) drop_flag <= 1'b1;
    end
    if (better) begin
      best_idx    <= cmp_idx;
      best_size   <= rd_size;
      best_handle <= rd_handle;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.load_out) begin
      found          <= hit;
      granted_handle <= hit ? best_handle : '0;
      granted_size   <= (req_kind == bfbp_pkg::KIND_RELEASE) ? '0 :
                        (hit ? best_size : req_size);
      dropped        <= drop_flag;
    end
  end

  // status to the controller
  always_comb begin
    sts.is_release = (req_kind == bfbp_pkg::KIND_RELEASE);
    sts.count_zero = (entry_count == '0);
    sts.can_append = (CMP_W'(entry_count) < CMP_W'(pool_limit)) &&
                     (entry_count < CNT_W'(POOL_DEPTH));
    sts.scan_last  = (CNT_W'(scan_idx) == count_m1);
    sts.hit        = hit;
    sts.out_free   = !out_valid || out_ready;
  end

endmodule

### hw/rtl/best_fit_block_pool_unit.sv
// best_fit_block_pool_unit: top level, controller plus datapath
// depends on bfbp_pkg, bfbp_ctrl, bfbp_dp
//
// Pool of released blocks with best-fit reuse. Each item is a release
// (append handle and size, or report dropped when the pool is at its limit
// or full) or an allocate (smallest pooled block with size at least the
// request, lowest slot on a tie, then swap-remove with the last entry). One
// item is in work at a time. A release or an allocate on an empty pool is
// dispatched and then loads its result once the result register is free.
// An allocate on a non-empty pool is dispatched, steps the single read port
// of the pool memory through every entry, drains the compare, checks the
// hit and reads the last entry, writes it into the freed slot (hit only)
// and loads the result in the same way. The controller is back in idle in
// the cycle after the result loads, so a new item can follow at once. The
// result register lets the next request transfer while a result waits.
// pool_limit is written through cfg_we/cfg_wdata; the user keeps such writes
// to idle, the block itself does not enforce it. The memory needs no
// clearing after reset.
module best_fit_block_pool_unit #(
  parameter int POOL_DEPTH = bfbp_pkg::POOL_DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bfbp_pkg::LIMIT_W-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [bfbp_pkg::SIZE_W-1:0]   block_size,
  input  logic [bfbp_pkg::HANDLE_W-1:0] release_handle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          found,
  output logic [bfbp_pkg::HANDLE_W-1:0] granted_handle,
  output logic [bfbp_pkg::SIZE_W-1:0]   granted_size,
  output logic                          dropped
);

  bfbp_pkg::bfbp_cmd_t    cmd;
  bfbp_pkg::bfbp_status_t sts;

  assign in_ready = cmd.in_ready;

  // sequencer
  bfbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  // pool storage and compare
  bfbp_dp #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .kind           (kind),
    .block_size     (block_size),
    .release_handle (release_handle),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .found          (found),
    .granted_handle (granted_handle),
    .granted_size   (granted_size),
    .dropped        (dropped),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

### hw/rtl/bfbp_checker.sv
// bfbp_checker: port-level checks for best_fit_block_pool_unit and the
// bind that attaches them; depends on bfbp_pkg
module bfbp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          found,
  input logic [bfbp_pkg::HANDLE_W-1:0] granted_handle,
  input logic                          dropped
);

  // a waiting result stays until transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // one request in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in work");

  // a miss or release carries no handle
  a_no_handle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> granted_handle == '0)
    else $error("handle on a result without a hit");

  // a result is never both a hit and a drop
  a_hit_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(found && dropped))
    else $error("hit and drop in one result");

endmodule

bind best_fit_block_pool_unit bfbp_checker u_bfbp_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .found          (found),
  .granted_handle (granted_handle),
  .dropped        (dropped)
);

### sim/best_fit_block_pool_unit_test.sv
`timescale 1ns / 100ps
// best_fit_block_pool_unit_test: self-checking bench for the best-fit block pool unit
// drives alloc/release transfers in bursts, predicts each result from a behavioral pool
// depends on bfbp_pkg and best_fit_block_pool_unit
module best_fit_block_pool_unit_test;

  localparam int DEPTH         = bfbp_pkg::POOL_DEPTH_DEFAULT;
  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 30;
  localparam logic [bfbp_pkg::SIZE_W-1:0] SIZE_MAX = '1;

  typedef struct packed {
    logic                          kind;
    logic [bfbp_pkg::SIZE_W-1:0]   size;
    logic [bfbp_pkg::HANDLE_W-1:0] handle;
  } pool_req_t;

  typedef struct packed {
    logic                          found;
    logic [bfbp_pkg::HANDLE_W-1:0] handle;
    logic [bfbp_pkg::SIZE_W-1:0]   size;
    logic                          dropped;
  } pool_grant_t;

  logic                          clk;
  logic                          rst            = 1'b1;
  logic                          cfg_we         = 1'b0;
  logic [bfbp_pkg::LIMIT_W-1:0]  cfg_wdata      = '0;
  logic                          in_valid       = 1'b0;
  logic                          in_ready;
  logic                          kind           = bfbp_pkg::KIND_ALLOC;
  logic [bfbp_pkg::SIZE_W-1:0]   block_size     = '0;
  logic [bfbp_pkg::HANDLE_W-1:0] release_handle = '0;
  logic                          out_valid;
  logic                          out_ready      = 1'b0;
  logic                          found;
  logic [bfbp_pkg::HANDLE_W-1:0] granted_handle;
  logic [bfbp_pkg::SIZE_W-1:0]   granted_size;
  logic                          dropped;

  best_fit_block_pool_unit dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .block_size     (block_size),
    .release_handle (release_handle),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .found          (found),
    .granted_handle (granted_handle),
    .granted_size   (granted_size),
    .dropped        (dropped)
  );

  // behavioral copy of the pool
  logic [bfbp_pkg::HANDLE_W-1:0] pool_handle [DEPTH];
  logic [bfbp_pkg::SIZE_W-1:0]   pool_size   [DEPTH];
  int                            pool_count  = 0;
  logic [bfbp_pkg::LIMIT_W-1:0]  pool_limit  = bfbp_pkg::LIMIT_RESET;

  pool_req_t   req_queue[$];
  pool_grant_t grant_queue[$];
  int          queued_reqs = 0;
  int          taken_reqs  = 0;
  int          errors      = 0;
  int          idle_cycles = 0;
  logic        in_xfer     = 1'b0;
  int          burst_left  = 0;
  int          gap_left    = 0;
  int          stall_left  = 0;
  int          stall_pct   = 0;
  int          stall_epoch = 0;

  // best-fit lookup with swap-remove, or append / drop on release
  function automatic pool_grant_t serve_request(pool_req_t r);
    pool_grant_t g;
    logic        hit;
    int          best;
    int          lim;
    int          i;
    g    = '0;
    hit  = 1'b0;
    best = 0;
    if (r.kind == bfbp_pkg::KIND_ALLOC) begin
      for (i = 0; i < pool_count; i++) begin
        if (pool_size[i] >= r.size && (!hit || pool_size[i] < pool_size[best])) begin
          hit  = 1'b1;
          best = i;
        end
      end
      if (hit) begin
        g.found           = 1'b1;
        g.handle          = pool_handle[best];
        g.size            = pool_size[best];
        pool_handle[best] = pool_handle[pool_count-1];
        pool_size[best]   = pool_size[pool_count-1];
        pool_count--;
      end else begin
        g.size = r.size;
      end
    end else begin
      // limits above the pool depth saturate
      lim = (pool_limit > DEPTH) ? DEPTH : int'(pool_limit);
      if (pool_count < lim) begin
        pool_handle[pool_count] = r.handle;
        pool_size[pool_count]   = r.size;
        pool_count++;
      end else begin
        g.dropped = 1'b1;
      end
    end
    return g;
  endfunction

  // sizes skewed toward a small range so that allocs hit often
  function automatic logic [bfbp_pkg::SIZE_W-1:0] pick_size();
    logic [bfbp_pkg::SIZE_W-1:0] s;
    case ($urandom_range(0, 9))
      0:       s = SIZE_MAX;
      1:       s = '0;
      2, 3:    s = bfbp_pkg::SIZE_W'($urandom);
      default: s = bfbp_pkg::SIZE_W'($urandom_range(0, 31));
    endcase
    return s;
  endfunction

  task automatic queue_req(logic k, logic [bfbp_pkg::SIZE_W-1:0] s,
                           logic [bfbp_pkg::HANDLE_W-1:0] h);
    pool_req_t r;
    r.kind   = k;
    r.size   = s;
    r.handle = h;
    req_queue.push_back(r);
    queued_reqs++;
  endtask

  // hold until every queued request is taken and every result is back
  task automatic drain_pool();
    do @(negedge clk);
    while (taken_reqs != queued_reqs || grant_queue.size() != 0);
  endtask

  task automatic write_limit(logic [bfbp_pkg::LIMIT_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(logic [bfbp_pkg::LIMIT_W-1:0] lim, int release_pct, int n);
    logic k;
    drain_pool();
    write_limit(lim);
    repeat (n) begin
      k = ($urandom_range(1, 100) <= release_pct) ? bfbp_pkg::KIND_RELEASE
                                                  : bfbp_pkg::KIND_ALLOC;
      queue_req(k, pick_size(), $urandom);
    end
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // request driver: bursts of transfers with random gaps between them
  always @(negedge clk) begin
    pool_req_t r;
    if (!rst && (!in_valid || in_xfer)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (req_queue.size() != 0) begin
        r = req_queue.pop_front();
        kind           <= r.kind;
        block_size     <= r.size;
        release_handle <= r.handle;
        in_valid       <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: stall density changes from epoch to epoch
  always @(negedge clk) begin
    if (stall_epoch == 0) begin
      stall_epoch = $urandom_range(50, 300);
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 15;
        2:       stall_pct = 35;
        default: stall_pct = 60;
      endcase
    end else begin
      stall_epoch--;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 15);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: config writes, result checks, then predictions for new requests
  always @(posedge clk) begin
    pool_grant_t want;
    in_xfer <= in_valid && in_ready;
    if (!rst) begin
      if (cfg_we) begin
        pool_limit = cfg_wdata;
      end
      if (out_valid && out_ready) begin
        if (grant_queue.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: found %0b handle %h size %h dropped %0b",
                   $time, found, granted_handle, granted_size, dropped);
        end else begin
          want = grant_queue.pop_front();
          if (found !== want.found) begin
            errors++;
            $display("%0t: found: expected %0b actual %0b", $time, want.found, found);
          end
          if (granted_handle !== want.handle) begin
            errors++;
            $display("%0t: granted_handle: expected %h actual %h",
                     $time, want.handle, granted_handle);
          end
          if (granted_size !== want.size) begin
            errors++;
            $display("%0t: granted_size: expected %h actual %h",
                     $time, want.size, granted_size);
          end
          if (dropped !== want.dropped) begin
            errors++;
            $display("%0t: dropped: expected %0b actual %0b", $time, want.dropped, dropped);
          end
        end
      end
      if (in_valid && in_ready) begin
        grant_queue.push_back(serve_request({kind, block_size, release_handle}));
        taken_reqs++;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // stimulus sequence
  initial begin
    logic [bfbp_pkg::LIMIT_W-1:0] limits [9];
    int                           rel_pcts [9];
    int                           counts   [9];
    int                           p;

    limits   = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd8, 5'd17, 5'd2, 5'd16, 5'd5};
    rel_pcts = '{70, 50, 75, 40, 55, 60, 50, 50, 30};
    counts   = '{70, 50, 70, 50, 60, 60, 50, 80, 60};

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty pool: allocs at both size extremes miss, handle field ignored
    queue_req(bfbp_pkg::KIND_ALLOC, '0, 32'hFFFF_FFFF);
    queue_req(bfbp_pkg::KIND_ALLOC, SIZE_MAX, 32'h1357_9BDF);
    // fill with extreme handles and sizes plus a size tie
    queue_req(bfbp_pkg::KIND_RELEASE, '0, '0);
    queue_req(bfbp_pkg::KIND_RELEASE, SIZE_MAX, 32'hFFFF_FFFF);
    queue_req(bfbp_pkg::KIND_RELEASE, 31'd100, 32'hA5A5_A5A5);
    queue_req(bfbp_pkg::KIND_RELEASE, 31'd100, 32'h5A5A_5A5A);
    queue_req(bfbp_pkg::KIND_RELEASE, 31'd50, 32'h1234_5678);
    // tie goes to the lower slot, swap-remove reorders the rest
    queue_req(bfbp_pkg::KIND_ALLOC, 31'd100, 32'hDEAD_BEEF);
    queue_req(bfbp_pkg::KIND_ALLOC, 31'd100, '0);
    queue_req(bfbp_pkg::KIND_ALLOC, SIZE_MAX, '0);
    queue_req(bfbp_pkg::KIND_ALLOC, '0, '0);
    queue_req(bfbp_pkg::KIND_ALLOC, 31'd1, '0);
    queue_req(bfbp_pkg::KIND_ALLOC, 31'd1, '0);

    // small limit: the release past it is dropped
    drain_pool();
    write_limit(5'd3);
    queue_req(bfbp_pkg::KIND_RELEASE, 31'd7, 32'd1);
    queue_req(bfbp_pkg::KIND_RELEASE, 31'd7, 32'd2);
    queue_req(bfbp_pkg::KIND_RELEASE, 31'd7, 32'd3);
    queue_req(bfbp_pkg::KIND_RELEASE, 31'd7, 32'd4);

    // limit lowered below the count: entries stay, releases drop until it falls
    drain_pool();
    write_limit(5'd1);
    queue_req(bfbp_pkg::KIND_RELEASE, 31'd9, 32'd5);
    queue_req(bfbp_pkg::KIND_ALLOC, 31'd7, '0);
    queue_req(bfbp_pkg::KIND_RELEASE, 31'd9, 32'd6);
    queue_req(bfbp_pkg::KIND_ALLOC, 31'd7, '0);
    queue_req(bfbp_pkg::KIND_ALLOC, 31'd7, '0);
    queue_req(bfbp_pkg::KIND_RELEASE, 31'd9, 32'd7);

    // zero limit drops every release
    drain_pool();
    write_limit(5'd0);
    queue_req(bfbp_pkg::KIND_RELEASE, 31'd3, 32'd8);
    queue_req(bfbp_pkg::KIND_ALLOC, '0, '0);

    // random phases over a spread of limits, each entered with the pool idle
    for (p = 0; p < 9; p++) begin
      run_phase(limits[p], rel_pcts[p], counts[p]);
    end

    drain_pool();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### best_fit_block_pool_unit.f
hw/rtl/bfbp_pkg.sv
hw/rtl/bfbp_ctrl.sv
hw/rtl/bfbp_dp.sv
hw/rtl/best_fit_block_pool_unit.sv
hw/rtl/bfbp_checker.sv
sim/best_fit_block_pool_unit_test.sv
